### hw/rtl/tsp_pkg.sv
package tsp_pkg;

    localparam int DATA_W  = 8;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 64;
    localparam int INDEX_W = 32;
    localparam int CNT_W   = 4;

    localparam int HASH_BYTES_DEFAULT = 32;

    localparam logic [DATA_W-1:0] VARINT_PREFIX_16 = 8'hfd;
    localparam logic [DATA_W-1:0] VARINT_PREFIX_32 = 8'hfe;

    localparam logic [CNT_W-1:0] FIXED_LEN_4 = 4'd4;
    localparam logic [CNT_W-1:0] FIXED_LEN_8 = 4'd8;
    localparam logic [CNT_W-1:0] VARINT_LEN_2 = 4'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_VERSION   = 4'd0,
        KIND_INCOUNT   = 4'd1,
        KIND_HASHBYTE  = 4'd2,
        KIND_PREVINDEX = 4'd3,
        KIND_SIGLEN    = 4'd4,
        KIND_SIGBYTE   = 4'd5,
        KIND_SEQ       = 4'd6,
        KIND_OUTCOUNT  = 4'd7,
        KIND_AMOUNT    = 4'd8,
        KIND_PKLEN     = 4'd9,
        KIND_PKBYTE    = 4'd10,
        KIND_LOCKTIME  = 4'd11
    } field_kind_t;

endpackage

### hw/rtl/tsp_in_if.sv
interface tsp_in_if;

    logic                        valid;
    logic                        ready;
    logic [tsp_pkg::DATA_W-1:0]  data_byte;
    logic                        start_of_tx;

    modport source (output valid, output data_byte, output start_of_tx, input ready);
    modport sink   (input valid, input data_byte, input start_of_tx, output ready);

endinterface

### hw/rtl/tsp_out_if.sv
interface tsp_out_if;

    logic                         valid;
    logic                         ready;
    logic [tsp_pkg::KIND_W-1:0]   field_kind;
    logic [tsp_pkg::VALUE_W-1:0]  field_value;
    logic [tsp_pkg::INDEX_W-1:0]  item_index;
    logic                         last;

    modport source (
        output valid, output field_kind, output field_value, output item_index,
        output last, input ready
    );
    modport sink (
        input valid, input field_kind, input field_value, input item_index,
        input last, output ready
    );

endinterface

### hw/rtl/transaction_stream_parser.sv
// Streaming parser for a serialized legacy transaction. It takes one byte beat per clock
// cycle while its output register can accept, and produces at most one field beat per byte,
// registered in the cycle after the byte is taken, from a single output register. A byte is
// taken whenever that register is empty or is being read in the same cycle, so with a ready
// sink the parser sustains one byte per cycle with no gaps; the rate is set by the single
// pass of phase, accumulator and counter logic between the byte and the output register. A
// byte flagged start_of_tx restarts parsing at the version field. After the lock time beat,
// flagged last, bytes are dropped until the next start.
module transaction_stream_parser #(
    parameter int HASH_BYTES = tsp_pkg::HASH_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    tsp_in_if.sink      byte_stream,
    tsp_out_if.source   field_stream
);

    typedef enum logic [12:0] {
        PH_VERSION   = 13'b0000000000001,
        PH_INCOUNT   = 13'b0000000000010,
        PH_HASH      = 13'b0000000000100,
        PH_PREVINDEX = 13'b0000000001000,
        PH_SIGLEN    = 13'b0000000010000,
        PH_SIGBYTE   = 13'b0000000100000,
        PH_SEQ       = 13'b0000001000000,
        PH_OUTCOUNT  = 13'b0000010000000,
        PH_AMOUNT    = 13'b0000100000000,
        PH_PKLEN     = 13'b0001000000000,
        PH_PKBYTE    = 13'b0010000000000,
        PH_LOCKTIME  = 13'b0100000000000,
        PH_IDLE      = 13'b1000000000000
    } phase_t;

    localparam int VW = tsp_pkg::VALUE_W;
    localparam int IW = tsp_pkg::INDEX_W;
    localparam int CW = tsp_pkg::CNT_W;

    phase_t             phase_reg, phase_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [VW-1:0]      acc_reg, acc_next;
    logic [CW-1:0]      vsz_reg, vsz_next;
    logic [VW-1:0]      brem_reg, brem_next;
    logic [VW-1:0]      irem_reg, irem_next;
    logic [IW-1:0]      eidx_reg, eidx_next;

    logic                        out_valid_reg;
    tsp_pkg::field_kind_t        kind_reg, kind_next;
    logic [VW-1:0]               value_reg, value_next;
    logic [IW-1:0]               index_reg, index_next;
    logic                        last_reg, last_next;
    logic                        emit;

    logic                        in_fire;
    logic                        start;
    logic [tsp_pkg::DATA_W-1:0]  b;
    phase_t                      ph;
    logic [CW-1:0]               cnt;
    logic [VW-1:0]               acc;
    logic [CW-1:0]               vsz;
    logic [VW-1:0]               brem;
    logic [VW-1:0]               irem;
    logic [IW-1:0]               eidx;

    logic [CW-1:0]               cnt_inc;
    logic [CW-1:0]               fix_n;
    logic                        fix_done;
    logic [VW-1:0]               acc_shift;
    logic                        is_varint;
    logic                        vint_prefix;
    logic                        vint_done;
    logic [VW-1:0]               vint_val;
    logic [VW-1:0]               brem_dec;
    logic [VW-1:0]               irem_dec;
    logic [IW-1:0]               eidx_bump;

    assign byte_stream.ready = !out_valid_reg || field_stream.ready;
    assign in_fire = byte_stream.valid && byte_stream.ready;

    assign start = byte_stream.start_of_tx;
    assign b     = byte_stream.data_byte;

    always_comb
    begin
        ph   = start ? PH_VERSION : phase_reg;
        cnt  = start ? '0 : cnt_reg;
        acc  = start ? '0 : acc_reg;
        vsz  = start ? '0 : vsz_reg;
        brem = start ? '0 : brem_reg;
        irem = start ? '0 : irem_reg;
        eidx = start ? '0 : eidx_reg;

        is_varint = (ph == PH_INCOUNT) || (ph == PH_SIGLEN) || (ph == PH_OUTCOUNT)
                 || (ph == PH_PKLEN);
        cnt_inc   = cnt + CW'(1);
        fix_n     = is_varint ? vsz
                  : ((ph == PH_AMOUNT) ? tsp_pkg::FIXED_LEN_8 : tsp_pkg::FIXED_LEN_4);
        fix_done  = (cnt_inc >= fix_n);
        acc_shift = acc | (VW'(b) << {cnt[2:0], 3'b000});

        vint_prefix = (vsz == '0);
        vint_done   = vint_prefix ? (b < tsp_pkg::VARINT_PREFIX_16) : fix_done;
        vint_val    = vint_prefix ? VW'(b) : acc_shift;

        brem_dec  = brem - VW'(1);
        irem_dec  = irem - VW'(1);
        eidx_bump = (eidx != '1) ? eidx + IW'(1) : eidx;

        phase_next = ph;
        cnt_next   = cnt;
        acc_next   = acc;
        vsz_next   = vsz;
        brem_next  = brem;
        irem_next  = irem;
        eidx_next  = eidx;

        emit       = 1'b0;
        kind_next  = tsp_pkg::KIND_VERSION;
        value_next = acc_shift;
        index_next = eidx;
        last_next  = 1'b0;

        if (is_varint)
        begin
            if (vint_prefix)
            begin
                if (!vint_done)
                begin
                    vsz_next = (b == tsp_pkg::VARINT_PREFIX_16) ? tsp_pkg::VARINT_LEN_2
                             : (b == tsp_pkg::VARINT_PREFIX_32) ? tsp_pkg::FIXED_LEN_4
                             : tsp_pkg::FIXED_LEN_8;
                    acc_next = '0;
                    cnt_next = '0;
                end
            end
            else if (fix_done)
            begin
                vsz_next = '0;
                acc_next = '0;
                cnt_next = '0;
            end
            else
            begin
                acc_next = acc_shift;
                cnt_next = cnt_inc;
            end
        end
        else if (ph == PH_VERSION || ph == PH_PREVINDEX || ph == PH_SEQ
              || ph == PH_AMOUNT || ph == PH_LOCKTIME)
        begin
            acc_next = fix_done ? '0 : acc_shift;
            cnt_next = fix_done ? '0 : cnt_inc;
        end

        case (ph)
            PH_VERSION:
            begin
                if (fix_done)
                begin
                    emit       = 1'b1;
                    kind_next  = tsp_pkg::KIND_VERSION;
                    index_next = '0;
                    phase_next = PH_INCOUNT;
                end
            end
            PH_INCOUNT:
            begin
                if (vint_done)
                begin
                    emit       = 1'b1;
                    kind_next  = tsp_pkg::KIND_INCOUNT;
                    value_next = vint_val;
                    index_next = '0;
                    irem_next  = vint_val;
                    eidx_next  = '0;
                    if (vint_val == '0)
                    begin
                        phase_next = PH_OUTCOUNT;
                    end
                    else
                    begin
                        brem_next  = VW'(HASH_BYTES);
                        phase_next = PH_HASH;
                    end
                end
            end
            PH_HASH:
            begin
                emit       = 1'b1;
                kind_next  = tsp_pkg::KIND_HASHBYTE;
                value_next = VW'(b);
                brem_next  = brem_dec;
                if (brem_dec == '0)
                begin
                    phase_next = PH_PREVINDEX;
                end
            end
            PH_PREVINDEX:
            begin
                if (fix_done)
                begin
                    emit       = 1'b1;
                    kind_next  = tsp_pkg::KIND_PREVINDEX;
                    phase_next = PH_SIGLEN;
                end
            end
            PH_SIGLEN:
            begin
                if (vint_done)
                begin
                    emit       = 1'b1;
                    kind_next  = tsp_pkg::KIND_SIGLEN;
                    value_next = vint_val;
                    brem_next  = vint_val;
                    phase_next = (vint_val == '0) ? PH_SEQ : PH_SIGBYTE;
                end
            end
            PH_SIGBYTE:
            begin
                emit       = 1'b1;
                kind_next  = tsp_pkg::KIND_SIGBYTE;
                value_next = VW'(b);
                brem_next  = brem_dec;
                if (brem_dec == '0)
                begin
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                if (fix_done)
                begin
                    emit      = 1'b1;
                    kind_next = tsp_pkg::KIND_SEQ;
                    irem_next = irem_dec;
                    if (irem_dec == '0)
                    begin
                        phase_next = PH_OUTCOUNT;
                    end
                    else
                    begin
                        eidx_next  = eidx_bump;
                        brem_next  = VW'(HASH_BYTES);
                        phase_next = PH_HASH;
                    end
                end
            end
            PH_OUTCOUNT:
            begin
                if (vint_done)
                begin
                    emit       = 1'b1;
                    kind_next  = tsp_pkg::KIND_OUTCOUNT;
                    value_next = vint_val;
                    index_next = '0;
                    irem_next  = vint_val;
                    eidx_next  = '0;
                    phase_next = (vint_val == '0) ? PH_LOCKTIME : PH_AMOUNT;
                end
            end
            PH_AMOUNT:
            begin
                if (fix_done)
                begin
                    emit       = 1'b1;
                    kind_next  = tsp_pkg::KIND_AMOUNT;
                    phase_next = PH_PKLEN;
                end
            end
            PH_PKLEN:
            begin
                if (vint_done)
                begin
                    emit       = 1'b1;
                    kind_next  = tsp_pkg::KIND_PKLEN;
                    value_next = vint_val;
                    brem_next  = vint_val;
                    if (vint_val == '0)
                    begin
                        irem_next = irem_dec;
                        if (irem_dec == '0)
                        begin
                            phase_next = PH_LOCKTIME;
                        end
                        else
                        begin
                            eidx_next  = eidx_bump;
                            phase_next = PH_AMOUNT;
                        end
                    end
                    else
                    begin
                        phase_next = PH_PKBYTE;
                    end
                end
            end
            PH_PKBYTE:
            begin
                emit       = 1'b1;
                kind_next  = tsp_pkg::KIND_PKBYTE;
                value_next = VW'(b);
                brem_next  = brem_dec;
                if (brem_dec == '0)
                begin
                    irem_next = irem_dec;
                    if (irem_dec == '0)
                    begin
                        phase_next = PH_LOCKTIME;
                    end
                    else
                    begin
                        eidx_next  = eidx_bump;
                        phase_next = PH_AMOUNT;
                    end
                end
            end
            PH_LOCKTIME:
            begin
                if (fix_done)
                begin
                    emit       = 1'b1;
                    kind_next  = tsp_pkg::KIND_LOCKTIME;
                    index_next = '0;
                    last_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = ph;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_VERSION;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            vsz_reg       <= '0;
            brem_reg      <= '0;
            irem_reg      <= '0;
            eidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                acc_reg       <= acc_next;
                vsz_reg       <= vsz_next;
                brem_reg      <= brem_next;
                irem_reg      <= irem_next;
                eidx_reg      <= eidx_next;
                out_valid_reg <= emit;
            end
            else if (field_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            index_reg <= index_next;
            last_reg  <= last_next;
        end
    end

    assign field_stream.valid       = out_valid_reg;
    assign field_stream.field_kind  = kind_reg;
    assign field_stream.field_value = value_reg;
    assign field_stream.item_index  = index_reg;
    assign field_stream.last        = last_reg;

    a_last_is_locktime: assert property (@(posedge clk) disable iff (!rst_n)
        field_stream.valid && field_stream.last
        |-> field_stream.field_kind == tsp_pkg::KIND_LOCKTIME)
        else $error("last flagged on a beat other than lock time");

    a_header_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        field_stream.valid && (field_stream.field_kind == tsp_pkg::KIND_VERSION
            || field_stream.field_kind == tsp_pkg::KIND_INCOUNT
            || field_stream.field_kind == tsp_pkg::KIND_OUTCOUNT
            || field_stream.field_kind == tsp_pkg::KIND_LOCKTIME)
        |-> field_stream.item_index == '0)
        else $error("nonzero item index on a transaction-level field");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && start
        |=> phase_reg == PH_VERSION && cnt_reg == CW'(1) && !out_valid_reg)
        else $error("start byte did not restart the version field");

    a_varint_size_legal: assert property (@(posedge clk) disable iff (!rst_n)
        vsz_reg == '0 || vsz_reg == tsp_pkg::VARINT_LEN_2
        || vsz_reg == tsp_pkg::FIXED_LEN_4 || vsz_reg == tsp_pkg::FIXED_LEN_8)
        else $error("illegal varint size");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < tsp_pkg::FIXED_LEN_8)
        else $error("field byte count out of range");

endmodule

### tb/transaction_stream_parser_test.sv
module transaction_stream_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HASH_LEN = tsp_pkg::HASH_BYTES_DEFAULT;
    localparam int ITEM_TARGET = 1500;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTED = 50;
    localparam logic [tsp_pkg::DATA_W-1:0] VARINT_PREFIX_64 = 8'hff;

    typedef enum logic [3:0] {
        ST_VERSION,
        ST_INCOUNT,
        ST_HASH,
        ST_PREVINDEX,
        ST_SIGLEN,
        ST_SIGBYTE,
        ST_SEQ,
        ST_OUTCOUNT,
        ST_AMOUNT,
        ST_PKLEN,
        ST_PKBYTE,
        ST_LOCKTIME,
        ST_IDLE
    } parse_step_t;

    typedef struct packed {
        tsp_pkg::field_kind_t              kind;
        logic [tsp_pkg::VALUE_W-1:0]       value;
        logic [tsp_pkg::INDEX_W-1:0]       index;
        logic                              last;
    } field_beat_t;

    typedef struct {
        logic [tsp_pkg::DATA_W-1:0] data;
        logic                       sof;
    } byte_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    tsp_in_if  byte_if();
    tsp_out_if field_if();

    transaction_stream_parser #(
        .HASH_BYTES(HASH_LEN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_if),
        .field_stream (field_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    byte_beat_t  tx_bytes[$];
    field_beat_t expected_fields[$];
    int          mismatches = 0;
    int          fields_seen = 0;
    logic        byte_taken = 1'b0;
    logic        field_taken = 1'b0;

    // Parser state mirrored by the predictor.
    parse_step_t                  step = ST_VERSION;
    int unsigned                  nbytes = 0;
    logic [tsp_pkg::VALUE_W-1:0]  acc = '0;
    int unsigned                  vlen = 0;
    logic [63:0]                  bytes_left = '0;
    logic [63:0]                  entries_left = '0;
    logic [tsp_pkg::INDEX_W-1:0]  entry = '0;

    function automatic bit shift_fixed(input logic [tsp_pkg::DATA_W-1:0] b,
                                       input int unsigned n,
                                       output logic [tsp_pkg::VALUE_W-1:0] v);
        acc = acc | (tsp_pkg::VALUE_W'(b) << (8 * (nbytes % 8)));
        nbytes++;
        v = acc;
        if (nbytes >= n)
        begin
            acc = '0;
            nbytes = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit take_count(input logic [tsp_pkg::DATA_W-1:0] b,
                                      output logic [tsp_pkg::VALUE_W-1:0] v);
        v = tsp_pkg::VALUE_W'(b);
        if (vlen == 0)
        begin
            if (b < tsp_pkg::VARINT_PREFIX_16)
                return 1'b1;
            vlen = (b == tsp_pkg::VARINT_PREFIX_16) ? int'(tsp_pkg::VARINT_LEN_2) :
                   (b == tsp_pkg::VARINT_PREFIX_32) ? int'(tsp_pkg::FIXED_LEN_4) :
                   int'(tsp_pkg::FIXED_LEN_8);
            acc = '0;
            nbytes = 0;
            return 1'b0;
        end
        if (shift_fixed(b, vlen, v))
        begin
            vlen = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic field_beat_t make_beat(input tsp_pkg::field_kind_t kind,
                                              input logic [tsp_pkg::VALUE_W-1:0] v,
                                              input bit per_entry, input bit is_last);
        field_beat_t beat;
        beat.kind = kind;
        beat.value = v;
        beat.index = per_entry ? entry : '0;
        beat.last = is_last;
        return beat;
    endfunction

    function automatic void begin_input();
        bytes_left = 64'(HASH_LEN);
        step = (bytes_left == 0) ? ST_PREVINDEX : ST_HASH;
    endfunction

    function automatic void next_entry();
        if (entry != '1)
            entry++;
    endfunction

    function automatic void end_input();
        entries_left--;
        if (entries_left == 0)
            step = ST_OUTCOUNT;
        else
        begin
            next_entry();
            begin_input();
        end
    endfunction

    function automatic void end_output();
        entries_left--;
        if (entries_left == 0)
            step = ST_LOCKTIME;
        else
        begin
            next_entry();
            step = ST_AMOUNT;
        end
    endfunction

    // Returns 1 when the byte completes a field beat, which is then placed in beat.
    function automatic bit parse_byte(input logic [tsp_pkg::DATA_W-1:0] b, input logic sof,
                                      output field_beat_t beat);
        logic [tsp_pkg::VALUE_W-1:0] v;
        beat = '0;
        if (sof)
        begin
            step = ST_VERSION;
            nbytes = 0;
            acc = '0;
            vlen = 0;
            bytes_left = '0;
            entries_left = '0;
            entry = '0;
        end
        case (step)
            ST_VERSION:
            begin
                if (!shift_fixed(b, tsp_pkg::FIXED_LEN_4, v))
                    return 1'b0;
                step = ST_INCOUNT;
                beat = make_beat(tsp_pkg::KIND_VERSION, v, 1'b0, 1'b0);
            end
            ST_INCOUNT:
            begin
                if (!take_count(b, v))
                    return 1'b0;
                entries_left = v;
                entry = '0;
                if (v == 0)
                    step = ST_OUTCOUNT;
                else
                    begin_input();
                beat = make_beat(tsp_pkg::KIND_INCOUNT, v, 1'b0, 1'b0);
            end
            ST_HASH:
            begin
                beat = make_beat(tsp_pkg::KIND_HASHBYTE, tsp_pkg::VALUE_W'(b), 1'b1, 1'b0);
                bytes_left--;
                if (bytes_left == 0)
                    step = ST_PREVINDEX;
            end
            ST_PREVINDEX:
            begin
                if (!shift_fixed(b, tsp_pkg::FIXED_LEN_4, v))
                    return 1'b0;
                step = ST_SIGLEN;
                beat = make_beat(tsp_pkg::KIND_PREVINDEX, v, 1'b1, 1'b0);
            end
            ST_SIGLEN:
            begin
                if (!take_count(b, v))
                    return 1'b0;
                bytes_left = v;
                step = (v == 0) ? ST_SEQ : ST_SIGBYTE;
                beat = make_beat(tsp_pkg::KIND_SIGLEN, v, 1'b1, 1'b0);
            end
            ST_SIGBYTE:
            begin
                beat = make_beat(tsp_pkg::KIND_SIGBYTE, tsp_pkg::VALUE_W'(b), 1'b1, 1'b0);
                bytes_left--;
                if (bytes_left == 0)
                    step = ST_SEQ;
            end
            ST_SEQ:
            begin
                if (!shift_fixed(b, tsp_pkg::FIXED_LEN_4, v))
                    return 1'b0;
                beat = make_beat(tsp_pkg::KIND_SEQ, v, 1'b1, 1'b0);
                end_input();
            end
            ST_OUTCOUNT:
            begin
                if (!take_count(b, v))
                    return 1'b0;
                entries_left = v;
                entry = '0;
                step = (v == 0) ? ST_LOCKTIME : ST_AMOUNT;
                beat = make_beat(tsp_pkg::KIND_OUTCOUNT, v, 1'b0, 1'b0);
            end
            ST_AMOUNT:
            begin
                if (!shift_fixed(b, tsp_pkg::FIXED_LEN_8, v))
                    return 1'b0;
                step = ST_PKLEN;
                beat = make_beat(tsp_pkg::KIND_AMOUNT, v, 1'b1, 1'b0);
            end
            ST_PKLEN:
            begin
                if (!take_count(b, v))
                    return 1'b0;
                bytes_left = v;
                beat = make_beat(tsp_pkg::KIND_PKLEN, v, 1'b1, 1'b0);
                if (v == 0)
                    end_output();
                else
                    step = ST_PKBYTE;
            end
            ST_PKBYTE:
            begin
                beat = make_beat(tsp_pkg::KIND_PKBYTE, tsp_pkg::VALUE_W'(b), 1'b1, 1'b0);
                bytes_left--;
                if (bytes_left == 0)
                    end_output();
            end
            ST_LOCKTIME:
            begin
                if (!shift_fixed(b, tsp_pkg::FIXED_LEN_4, v))
                    return 1'b0;
                step = ST_IDLE;
                beat = make_beat(tsp_pkg::KIND_LOCKTIME, v, 1'b0, 1'b1);
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void push_byte(input logic [tsp_pkg::DATA_W-1:0] b,
                                      input logic sof = 1'b0);
        byte_beat_t bb;
        bb.data = b;
        bb.sof = sof;
        tx_bytes = {tx_bytes, bb};
    endfunction

    function automatic void push_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            push_byte(v[8*i +: 8]);
    endfunction

    function automatic void push_version();
        push_byte(8'($urandom), 1'b1);
        push_le(64'($urandom), 3);
    endfunction

    // Counts and lengths are sometimes given a wider encoding than they need.
    function automatic void push_varint(input logic [63:0] v);
        int unsigned w;
        if (v < tsp_pkg::VARINT_PREFIX_16 && $urandom_range(0, 3) != 0)
        begin
            push_byte(v[7:0]);
            return;
        end
        if (v < 64'h1_0000)
            w = $urandom_range(0, 2);
        else if (v < 64'h1_0000_0000)
            w = $urandom_range(1, 2);
        else
            w = 2;
        case (w)
            0:
            begin
                push_byte(tsp_pkg::VARINT_PREFIX_16);
                push_le(v, 2);
            end
            1:
            begin
                push_byte(tsp_pkg::VARINT_PREFIX_32);
                push_le(v, 4);
            end
            default:
            begin
                push_byte(VARINT_PREFIX_64);
                push_le(v, 8);
            end
        endcase
    endfunction

    function automatic int unsigned pick_len();
        case ($urandom_range(0, 15))
            0, 1, 2, 3: return 0;
            15:         return $urandom_range(253, 300);
            default:    return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic int unsigned pick_count();
        case ($urandom_range(0, 9))
            0, 1:    return 0;
            7, 8:    return 2;
            9:       return 3;
            default: return 1;
        endcase
    endfunction

    function automatic void push_input_head();
        repeat (HASH_LEN) push_byte(8'($urandom));
        push_le(64'(($urandom_range(0, 7) == 0) ? 32'hffff_ffff : $urandom), 4);
    endfunction

    function automatic void push_transaction(input int unsigned n_in, input int unsigned n_out,
                                             input bit cut);
        int unsigned first;
        int unsigned len;
        first = tx_bytes.size();
        push_version();
        push_varint(64'(n_in));
        repeat (n_in)
        begin
            push_input_head();
            len = pick_len();
            push_varint(64'(len));
            repeat (len) push_byte(8'($urandom));
            push_le(64'($urandom), 4);
        end
        push_varint(64'(n_out));
        repeat (n_out)
        begin
            push_le({$urandom, $urandom}, 8);
            len = pick_len();
            push_varint(64'(len));
            repeat (len) push_byte(8'($urandom));
        end
        push_le(64'($urandom), 4);
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
        if (cut)
            repeat ($urandom_range(1, tx_bytes.size() - first - 1)) void'(tx_bytes.pop_back());
    endfunction

    // Counts or lengths far beyond what is sent; the next start aborts the transaction.
    function automatic void push_oversized();
        push_version();
        case ($urandom_range(0, 2))
            0:
            begin
                push_byte(VARINT_PREFIX_64);
                push_le({1'b1, 31'($urandom), $urandom}, 8);
                repeat (2)
                begin
                    push_input_head();
                    push_varint(64'(0));
                    push_le(64'($urandom), 4);
                end
            end
            1:
            begin
                push_varint(64'(1));
                push_input_head();
                push_byte(tsp_pkg::VARINT_PREFIX_32);
                push_le(64'({1'b1, 31'($urandom)}), 4);
                repeat ($urandom_range(1, 10)) push_byte(8'($urandom));
            end
            default:
            begin
                push_varint(64'(0));
                push_byte(VARINT_PREFIX_64);
                push_le({1'b1, 31'($urandom), $urandom}, 8);
                repeat (3)
                begin
                    push_le({$urandom, $urandom}, 8);
                    push_varint(64'(1));
                    push_byte(8'($urandom));
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Source side.
    int unsigned send_wait = 0;
    bit          send_calm = 1'b0;

    always @(negedge clk)
    begin : drive_bytes
        byte_beat_t nxt;
        if (rst_n && (!byte_if.valid || byte_taken))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                byte_if.valid <= 1'b0;
            end
            else if (tx_bytes.size() != 0)
            begin
                nxt = tx_bytes.pop_front();
                byte_if.valid <= 1'b1;
                byte_if.data_byte <= nxt.data;
                byte_if.start_of_tx <= nxt.sof;
                send_wait = send_calm ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 63) == 0)
                    send_calm = !send_calm;
            end
            else
                byte_if.valid <= 1'b0;
        end
    end

    // Sink side.
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    bit          recv_calm = 1'b0;
    bit          hold_done = 1'b0;

    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (field_taken)
            begin
                recv_wait = recv_calm ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 63) == 0)
                    recv_calm = !recv_calm;
            end
            if (!hold_done && fields_seen >= 100)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                field_if.ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                field_if.ready <= 1'b0;
            end
            else
                field_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : observe
        field_beat_t pred;
        field_beat_t want;
        if (rst_n)
        begin
            byte_taken <= byte_if.valid && byte_if.ready;
            field_taken <= field_if.valid && field_if.ready;
            if (byte_if.valid && byte_if.ready)
            begin
                if (parse_byte(byte_if.data_byte, byte_if.start_of_tx, pred))
                    expected_fields = {expected_fields, pred};
            end
            if (field_if.valid && field_if.ready)
            begin
                fields_seen++;
                if (expected_fields.size() == 0)
                    report_mismatch("field beat with nothing expected", field_if.field_value, '0);
                else
                begin
                    want = expected_fields.pop_front();
                    if (field_if.field_kind !== want.kind)
                        report_mismatch("field_kind", 64'(field_if.field_kind), 64'(want.kind));
                    if (field_if.field_value !== want.value)
                        report_mismatch("field_value", field_if.field_value, want.value);
                    if (field_if.item_index !== want.index)
                        report_mismatch("item_index", 64'(field_if.item_index), 64'(want.index));
                    if (field_if.last !== want.last)
                        report_mismatch("last", 64'(field_if.last), 64'(want.last));
                end
            end
        end
    end

    int unsigned stalled = 0;

    always @(posedge clk)
    begin : watchdog
        if (rst_n && !(byte_if.valid && byte_if.ready) && !(field_if.valid && field_if.ready))
            stalled++;
        else
            stalled = 0;
        if (stalled >= STALL_LIMIT)
        begin
            $display("FAIL transaction_stream_parser");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        byte_if.valid = 1'b0;
        byte_if.data_byte = '0;
        byte_if.start_of_tx = 1'b0;
        field_if.ready = 1'b0;

        // Bytes right after reset carry no start flag and still parse as a transaction
        // with no inputs and no outputs.
        push_le(64'(32'hffff_ffff), 4);
        push_byte(8'h00);
        push_byte(8'h00);
        push_le(64'(0), 4);
        // Dropped after the lock time.
        push_byte(8'haa);
        push_byte(8'h55);
        // Four-byte input count with its top bit set, cut short by the random part.
        push_byte(8'h01, 1'b1);
        push_le(64'(0), 3);
        push_byte(tsp_pkg::VARINT_PREFIX_32);
        push_le(64'(32'h8765_4321), 4);

        while (tx_bytes.size() < ITEM_TARGET)
        begin
            case ($urandom_range(0, 11))
                8:       push_transaction(pick_count(), pick_count(), 1'b1);
                9:       push_oversized();
                10:      repeat ($urandom_range(1, 16))
                             push_byte(8'($urandom), $urandom_range(0, 7) == 0);
                11:      push_transaction(0, 1, 1'b0);
                default: push_transaction(pick_count(), pick_count(), 1'b0);
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || byte_if.valid !== 1'b0)
            @(posedge clk);
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("PASS transaction_stream_parser");
        else
            $display("FAIL transaction_stream_parser");
        $finish;
    end

endmodule
